// ===== rtl/u8san_pkg.sv =====
// Shared types, constants and the UTF-8 prefix classifier for the stream sanitizer.
// No dependencies; imported by every module of the block.
package u8san_pkg;

  // Replacement character U+FFFD in UTF-8
  localparam logic [7:0] REPL_BYTE0 = 8'hEF;
  localparam logic [7:0] REPL_BYTE1 = 8'hBF;
  localparam logic [7:0] REPL_BYTE2 = 8'hBD;

  // Classifier result codes; 1..4 are complete sequence lengths
  localparam logic [2:0] CLS_BAD  = 3'd0;
  localparam logic [2:0] CLS_WAIT = 3'd5;

  // Token queue between front and back
  localparam int             QDEPTH    = 4;
  localparam int             QAW       = $clog2(QDEPTH);
  localparam logic [QAW:0]   QCNT_FULL = (QAW + 1)'(QDEPTH);

  // Index of the final byte of a replacement burst
  localparam logic [1:0] REPL_LAST_SUB = 2'd2;

  typedef enum logic {
    FS_IDLE,
    FS_SCAN
  } front_state_t;

  typedef enum logic {
    TOK_BYTE,
    TOK_REPL
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  data;
    logic        run_last;
    logic        stream_end;
    logic        stream_valid;
  } tok_t;

  typedef struct packed {
    logic vld;
    tok_t tok;
  } tok_push_t;

  // Classify n bytes (b0 first) as a complete sequence (length), a valid
  // unfinished prefix (CLS_WAIT) or a sequence that can never be valid.
  function automatic logic [2:0] classify(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic [2:0] n);
    logic [2:0] need;
    logic [7:0] lo;
    logic [7:0] hi;
    logic       bad;
    logic [2:0] res;
    lo   = 8'h80;
    hi   = 8'hBF;
    need = 3'd1;
    bad  = 1'b0;
    if (b0 <= 8'h7F) begin
      need = 3'd1;
    end else if (b0 >= 8'hC2 && b0 <= 8'hDF) begin
      need = 3'd2;
    end else if (b0 == 8'hE0) begin
      need = 3'd3;
      lo   = 8'hA0;
    end else if (b0 == 8'hED) begin
      need = 3'd3;
      hi   = 8'h9F;
    end else if (b0 >= 8'hE1 && b0 <= 8'hEF) begin
      need = 3'd3;
    end else if (b0 == 8'hF0) begin
      need = 3'd4;
      lo   = 8'h90;
    end else if (b0 >= 8'hF1 && b0 <= 8'hF3) begin
      need = 3'd4;
    end else if (b0 == 8'hF4) begin
      need = 3'd4;
      hi   = 8'h8F;
    end else begin
      bad = 1'b1;
    end
    if (need > 3'd1) begin
      if (n >= 3'd2 && (b1 < lo || b1 > hi)) bad = 1'b1;
      if (need >= 3'd3 && n >= 3'd3 && b2[7:6] != 2'b10) bad = 1'b1;
      if (need == 3'd4 && n >= 3'd4 && b3[7:6] != 2'b10) bad = 1'b1;
    end
    if (bad) begin
      res = CLS_BAD;
    end else if (n >= need) begin
      res = need;
    end else begin
      res = CLS_WAIT;
    end
    return res;
  endfunction

endpackage

// ===== rtl/u8san_front.sv =====
// Front end: accepts input beats, holds its unfinished sequence window, scans
// it to copy/replace tokens, one byte per cycle unless q_full. Uses u8san_pkg.
module u8san_front import u8san_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte
  input  logic       in_tlast,
  output tok_push_t  push_o,
  input  logic       q_full
);

  front_state_t state_r, state_nxt;
  logic [7:0]   w_r [4];
  logic [2:0]   cnt_r, cnt_nxt;
  logic [1:0]   copy_r, copy_nxt;
  logic         mal_r, mal_nxt;
  logic         last_r;

  logic [2:0] cls0;
  logic [2:0] cls1;
  logic [2:0] len_m1;
  logic       is_repl;
  logic       emit;
  logic       fin;
  logic       step;
  logic       accept;
  logic       tok_mal;

  // Classify the window head and the window one byte further on
  always_comb begin
    cls0    = classify(w_r[0], w_r[1], w_r[2], w_r[3], cnt_r);
    cls1    = classify(w_r[1], w_r[2], w_r[3], 8'h00, cnt_r - 3'd1);
    len_m1  = cls0 - 3'd1;
    is_repl = (copy_r == 2'd0) &&
              (cls0 == CLS_BAD || cls0 == CLS_WAIT || w_r[0] == 8'h00);
    emit    = (copy_r != 2'd0) || !(cls0 == CLS_WAIT && !last_r);
    if (copy_r != 2'd0) begin
      copy_nxt = copy_r - 2'd1;
    end else if (is_repl) begin
      copy_nxt = 2'd0;
    end else begin
      copy_nxt = len_m1[1:0];
    end
    fin     = (copy_nxt == 2'd0) &&
              (cnt_r == 3'd1 || (cls1 == CLS_WAIT && !last_r));
    step    = (state_r == FS_SCAN) && emit && !q_full;
    accept  = in_tvalid && in_tready;
    tok_mal = is_repl && (w_r[0] != 8'h00);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_IDLE: begin
        if (in_tvalid) state_nxt = FS_SCAN;
      end
      FS_SCAN: begin
        if (!emit || (step && fin)) state_nxt = FS_IDLE;
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  // Outputs: handshake and token
  always_comb begin
    in_tready                 = (state_r == FS_IDLE);
    push_o.vld                = step;
    push_o.tok.kind           = is_repl ? TOK_REPL : TOK_BYTE;
    push_o.tok.data           = w_r[0];
    push_o.tok.run_last       = fin;
    push_o.tok.stream_end     = fin && last_r;
    push_o.tok.stream_valid   = fin && last_r && !(mal_r || tok_mal);
  end

  // Count, copy run and malformed flag
  always_comb begin
    cnt_nxt = cnt_r;
    mal_nxt = mal_r;
    if (accept) begin
      cnt_nxt = cnt_r + 3'd1;
    end else if (step) begin
      cnt_nxt = cnt_r - 3'd1;
      if (tok_mal) mal_nxt = 1'b1;
      if (fin && last_r) begin
        cnt_nxt = 3'd0;
        mal_nxt = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      cnt_r   <= 3'd0;
      copy_r  <= 2'd0;
      mal_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      mal_r   <= mal_nxt;
      if (step) copy_r <= copy_nxt;
    end
  end

  // Window: append on accept, shift out one byte per token
  always_ff @(posedge clk) begin
    if (accept) begin
      w_r[cnt_r[1:0]] <= in_tdata;
      last_r          <= in_tlast;
    end else if (step) begin
      for (int i = 0; i < 3; i++) begin
        w_r[i] <= w_r[i+1];
      end
    end
  end

endmodule

// ===== rtl/u8san_fifo.sv =====
// Short token queue decoupling the scanner from the output stage.
// Uses u8san_pkg for the token type and depth.
module u8san_fifo import u8san_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tok_push_t push_i,
  input  logic      pop,
  output tok_t      head,
  output logic      full,
  output logic      empty
);

  tok_t           q_r [QDEPTH];
  logic [QAW-1:0] wr_r;
  logic [QAW-1:0] rd_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;

  always_comb begin
    full    = (cnt_r == QCNT_FULL);
    empty   = (cnt_r == '0);
    head    = q_r[rd_r];
    do_push = push_i.vld && !full;
    do_pop  = pop && !empty;
    cnt_nxt = cnt_r + (QAW + 1)'(do_push) - (QAW + 1)'(do_pop);
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_r <= wr_r + QAW'(1);
      if (do_pop)  rd_r <= rd_r + QAW'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_r] <= push_i.tok;
  end

endmodule

// ===== rtl/u8san_back.sv =====
// Back end: expands tokens into output beats (replacements become EF BF BD)
// and holds them in the output register. Uses u8san_pkg.
module u8san_back import u8san_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  tok_t       head,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] byte
  output logic       out_tlast,   // last beat caused by one input beat
  output logic [1:0] out_tuser    // [0] stream_end, [1] stream_valid
);

  logic [1:0] sub_r, sub_nxt;
  logic       vld_r;
  logic [7:0] data_r, data_nxt;
  logic       last_r;
  logic [1:0] user_r;
  logic       load;
  logic       take;
  logic       piece_last;

  // Select the next beat from the queue head
  always_comb begin
    load       = !vld_r || out_tready;
    take       = load && !q_empty;
    piece_last = (head.kind == TOK_BYTE) || (sub_r == REPL_LAST_SUB);
    pop        = take && piece_last;
    sub_nxt    = pop ? 2'd0 : sub_r + 2'd1;
    if (head.kind == TOK_BYTE) begin
      data_nxt = head.data;
    end else begin
      unique case (sub_r)
        2'd0:    data_nxt = REPL_BYTE0;
        2'd1:    data_nxt = REPL_BYTE1;
        default: data_nxt = REPL_BYTE2;
      endcase
    end
  end

  // Output valid and replacement position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sub_r <= 2'd0;
    end else begin
      if (load) vld_r <= !q_empty;
      if (take) sub_r <= sub_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
      last_r <= piece_last && head.run_last;
      user_r <= {piece_last && head.stream_valid, piece_last && head.stream_end};
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = user_r;

endmodule

// ===== rtl/utf8_stream_sanitizer_top.sv =====
// Top level of the UTF-8 stream sanitizer: scanner front, token queue, output back.
// Depends on u8san_pkg, u8san_front, u8san_fifo and u8san_back.
//
//   channel | dir | tdata        | tlast                 | tuser
//   in_     | in  | [7:0] byte   | final byte of stream  | -
//   out_    | out | [7:0] byte   | last beat of an input | [0] stream end, [1] stream valid
//
// An input beat is taken only while the scanner is idle; the scanner then
// consumes bytes from its 4-byte window, one per cycle while the queue has room,
// until the window is empty or holds only an unfinished prefix.
// Each replacement occupies the output for three beats.
// Output stalls back up through the 4-entry token queue into the scanner.
// Reset (rst_n low, synchronous) empties the window, queue and output register.
module utf8_stream_sanitizer_top import u8san_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic [1:0] out_tuser   // [0] stream_end, [1] stream_valid
);

  tok_push_t q_push;
  tok_t      q_head;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;

  u8san_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .push_o    (q_push),
    .q_full    (q_full)
  );

  u8san_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (q_push),
    .pop    (q_pop),
    .head   (q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  u8san_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  // Scanner never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.vld |-> !q_full) else $error("token pushed into full queue");

  // Stream end always closes an input's run
  a_end_has_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast) else $error("stream end without tlast");

  // Valid flag only appears on the stream end beat
  a_valid_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0]) else $error("stream valid off stream end");

  // Input is not taken while the scanner still has tokens to push
  a_idle_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !q_push.vld) else $error("push while idle");
`endif

endmodule

// ===== tb/utf8_stream_sanitizer_top_tb.sv =====
// Self-checking testbench for utf8_stream_sanitizer_top: directed rows, then random UTF-8 text.
// Holds its own byte-level sanitizer prediction; needs only the RTL of the block.
`timescale 1ns / 1ps

module utf8_stream_sanitizer_top_tb;

  localparam int  DIR_ROWS   = 25;
  localparam int  RAND_ITEMS = 85;
  localparam int  DRAIN_AT   = DIR_ROWS + 45;
  localparam int  HOLD_AT    = DIR_ROWS + 60;
  localparam int  LONG_HOLD  = 300;
  localparam int  TAIL       = 64;
  localparam int  LIMIT      = 200000;

  // Sequence classes: 1..4 are lengths of a complete sequence
  localparam int  SPAN_BAD   = 0;
  localparam int  SPAN_WAIT  = 5;

  // U+FFFD encoded as UTF-8
  localparam logic [7:0] R0 = 8'hEF;
  localparam logic [7:0] R1 = 8'hBF;
  localparam logic [7:0] R2 = 8'hBD;

  // How a stimulus row gets its expected beats
  localparam logic FROM_MODEL = 1'b0;
  localparam logic TYPED      = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       src;
    logic [1:0] n_out;
    logic [7:0] t0;
    logic [7:0] t1;
    logic [7:0] t2;
    logic       t_end;
    logic       t_valid;
  } raw_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
    logic       stream_valid;
  } clean_beat_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] in_byte
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic       out_tlast;
  logic [1:0] out_tuser;  // [0] stream_end, [1] stream_valid

  raw_item_t   raw_q[$];
  raw_item_t   dir_tbl [0:DIR_ROWS-1];
  clean_beat_t clean_q[$];
  clean_beat_t step_beats[$];

  // Predictor state
  logic [7:0] hold_buf [0:2];
  int         hold_cnt;
  logic       bad_seen;

  int raw_taken;
  int bad_beats;
  int cycles;

  utf8_stream_sanitizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Classify the bytes c0.. (n of them) as complete, unfinished or broken
  function automatic int utf8_span(input logic [7:0] c0, input logic [7:0] c1,
                                   input logic [7:0] c2, input logic [7:0] c3,
                                   input int n);
    int         need;
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (c0 <= 8'h7F) return 1;
    if (c0 >= 8'hC2 && c0 <= 8'hDF) need = 2;
    else if (c0 == 8'hE0) begin
      need = 3;
      lo   = 8'hA0;
    end else if (c0 == 8'hED) begin
      need = 3;
      hi   = 8'h9F;
    end else if (c0 >= 8'hE1 && c0 <= 8'hEF) need = 3;
    else if (c0 == 8'hF0) begin
      need = 4;
      lo   = 8'h90;
    end else if (c0 >= 8'hF1 && c0 <= 8'hF3) need = 4;
    else if (c0 == 8'hF4) begin
      need = 4;
      hi   = 8'h8F;
    end else return SPAN_BAD;
    if (n >= 2 && (c1 < lo || c1 > hi)) return SPAN_BAD;
    if (need >= 3 && n >= 3 && c2[7:6] != 2'b10) return SPAN_BAD;
    if (need == 4 && n >= 4 && c3[7:6] != 2'b10) return SPAN_BAD;
    return (n >= need) ? need : SPAN_WAIT;
  endfunction

  // Advance the predictor by one raw byte; leave its output beats in step_beats
  task automatic sanitize_byte(input logic [7:0] din, input logic last);
    logic [7:0] win [0:6];
    int         n;
    int         pos;
    int         len;
    int         i;
    for (i = 0; i < 7; i++) win[i] = 8'h00;
    step_beats.delete();
    for (i = 0; i < hold_cnt; i++) win[i] = hold_buf[i];
    win[hold_cnt] = din;
    n   = hold_cnt + 1;
    pos = 0;
    while (pos < n) begin
      len = utf8_span(win[pos], win[pos+1], win[pos+2], win[pos+3], n - pos);
      if (len == SPAN_WAIT && !last) break;
      if (len == SPAN_BAD || len == SPAN_WAIT || win[pos] == 8'h00) begin
        // NUL is replaced but keeps the stream valid
        if (win[pos] != 8'h00) bad_seen = 1'b1;
        step_beats.push_back('{R0, 1'b0, 1'b0, 1'b0});
        step_beats.push_back('{R1, 1'b0, 1'b0, 1'b0});
        step_beats.push_back('{R2, 1'b0, 1'b0, 1'b0});
        pos++;
      end else begin
        for (i = 0; i < len; i++) step_beats.push_back('{win[pos+i], 1'b0, 1'b0, 1'b0});
        pos += len;
      end
    end
    hold_cnt = n - pos;
    for (i = 0; i < hold_cnt; i++) hold_buf[i] = win[pos+i];
    if (step_beats.size() > 0) step_beats[step_beats.size()-1].run_last = 1'b1;
    if (last) begin
      if (step_beats.size() > 0) begin
        step_beats[step_beats.size()-1].stream_end   = 1'b1;
        step_beats[step_beats.size()-1].stream_valid = !bad_seen;
      end
      hold_cnt = 0;
      bad_seen = 1'b0;
    end
  endtask

  task automatic add_raw(input logic [7:0] d, input logic l);
    raw_item_t it;
    it      = '0;
    it.data = d;
    it.last = l;
    it.src  = FROM_MODEL;
    raw_q.push_back(it);
  endtask

  // Second byte of a sequence, mostly inside the range its lead allows
  function automatic logic [7:0] second_byte(input logic [7:0] lead);
    if ($urandom_range(9) == 0) return 8'($urandom_range(8'hBF, 8'h80));
    case (lead)
      8'hE0:   return 8'($urandom_range(8'hBF, 8'hA0));
      8'hED:   return 8'($urandom_range(8'h9F, 8'h80));
      8'hF0:   return 8'($urandom_range(8'hBF, 8'h90));
      8'hF4:   return 8'($urandom_range(8'h8F, 8'h80));
      default: return 8'($urandom_range(8'hBF, 8'h80));
    endcase
  endfunction

  // Build random text: mostly whole characters, some noise, NULs and broken sequences
  task automatic gen_random_text(input int count);
    logic [7:0] seq [0:3];
    int         len;
    int         keep;
    int         pick;
    int         i;
    int         made;
    logic       ends;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      len  = 1;
      if (pick < 28) seq[0] = 8'($urandom_range(8'h7F, 8'h01));
      else if (pick < 42) begin
        seq[0] = 8'($urandom_range(8'hDF, 8'hC2));
        len    = 2;
      end else if (pick < 62) begin
        seq[0] = 8'($urandom_range(8'hEF, 8'hE0));
        len    = 3;
      end else if (pick < 78) begin
        seq[0] = 8'($urandom_range(8'hF4, 8'hF0));
        len    = 4;
      end else if (pick < 86) seq[0] = 8'($urandom_range(255, 0));
      else if (pick < 90) seq[0] = 8'h00;
      else begin
        seq[0] = 8'($urandom_range(8'hF4, 8'hC2));
        len    = (seq[0] >= 8'hF0) ? 4 : (seq[0] >= 8'hE0) ? 3 : 2;
      end
      for (i = 1; i < len; i++) seq[i] = 8'($urandom_range(8'hBF, 8'h80));
      if (len > 1) seq[1] = second_byte(seq[0]);
      keep = len;
      // Break the sequence: cut it short or spoil one trailing byte
      if (pick >= 90) begin
        if ($urandom_range(1) == 1) keep = $urandom_range(len - 1, 1);
        else seq[$urandom_range(len - 1, 1)] = 8'($urandom_range(255, 0));
      end
      ends = ($urandom_range(11) == 0);
      for (i = 0; i < keep; i++) add_raw(seq[i], ends && (i == keep - 1));
      made += keep;
    end
    raw_q[raw_q.size()-1].last = 1'b1;
  endtask

  function automatic int sender_gap(input int idx);
    int p;
    if ((idx >= DIR_ROWS + 10 && idx < DIR_ROWS + 30) ||
        (idx >= HOLD_AT - 5 && idx < HOLD_AT + 30)) return 0;
    p = $urandom_range(99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(30, 10);
  endfunction

  // Predict on every accepted input beat
  always @(posedge clk) begin
    raw_item_t it;
    int        i;
    if (rst_n && in_tvalid && in_tready) begin
      it = raw_q[raw_taken];
      sanitize_byte(in_tdata, in_tlast);
      if (it.src == TYPED) begin
        for (i = 0; i < it.n_out; i++) begin
          clean_q.push_back('{(i == 0) ? it.t0 : (i == 1) ? it.t1 : it.t2,
                              i == it.n_out - 1,
                              (i == it.n_out - 1) && it.t_end,
                              (i == it.n_out - 1) && it.t_valid});
        end
      end else begin
        foreach (step_beats[i]) clean_q.push_back(step_beats[i]);
      end
      raw_taken++;
    end
  end

  // Compare each output beat with the oldest expected one
  always @(posedge clk) begin
    clean_beat_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (clean_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual data %h last %b user %b",
                 $time, out_tdata, out_tlast, out_tuser);
        bad_beats++;
      end else begin
        e = clean_q.pop_front();
        if (out_tdata !== e.data) begin
          $display("%0t: out_tdata expected %h actual %h", $time, e.data, out_tdata);
          bad_beats++;
        end
        if (out_tlast !== e.run_last) begin
          $display("%0t: out_tlast expected %b actual %b", $time, e.run_last, out_tlast);
          bad_beats++;
        end
        if (out_tuser[0] !== e.stream_end) begin
          $display("%0t: stream_end expected %b actual %b", $time, e.stream_end,
                   out_tuser[0]);
          bad_beats++;
        end
        if (out_tuser[1] !== e.stream_valid) begin
          $display("%0t: stream_valid expected %b actual %b", $time, e.stream_valid,
                   out_tuser[1]);
          bad_beats++;
        end
      end
    end
  end

  // Throttle the output side; hold off once for a long stretch
  initial begin
    int  stall_left;
    int  p;
    bit  held;
    out_tready = 1'b0;
    stall_left = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && raw_taken >= HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        held = 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        p = $urandom_range(99);
        if (!(raw_taken >= DIR_ROWS + 10 && raw_taken < DIR_ROWS + 30) && p < 25)
          stall_left = (p < 22) ? $urandom_range(3, 1) : $urandom_range(40, 10);
      end
    end
  end

  // Bound the run
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Reset, send every raw byte, then drain
  initial begin
    int idx;
    int gap;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    hold_cnt  = 0;
    bad_seen  = 1'b0;
    raw_taken = 0;
    bad_beats = 0;

    // Directed rows: extremes, NUL, bad leads, every lead class but F1..F3, truncation at stream end
    dir_tbl = '{
      '{8'h41, 1'b0, TYPED,      2'd1, 8'h41, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'h00, 1'b0, TYPED,      2'd3, R0,    R1,    R2,    1'b0, 1'b0},
      '{8'h7F, 1'b0, TYPED,      2'd1, 8'h7F, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'h80, 1'b0, TYPED,      2'd3, R0,    R1,    R2,    1'b0, 1'b0},
      '{8'hFF, 1'b0, TYPED,      2'd3, R0,    R1,    R2,    1'b0, 1'b0},
      '{8'hC2, 1'b0, TYPED,      2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'h80, 1'b0, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'hE0, 1'b0, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'h9F, 1'b0, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'hED, 1'b0, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'hA0, 1'b0, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'hF4, 1'b0, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'h90, 1'b0, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'hF0, 1'b0, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'h90, 1'b0, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'h80, 1'b0, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'h80, 1'b0, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'hF4, 1'b0, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'h8F, 1'b0, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'hBF, 1'b0, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'hBF, 1'b0, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'hE2, 1'b0, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'h82, 1'b1, FROM_MODEL, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
      '{8'h00, 1'b1, TYPED,      2'd3, R0,    R1,    R2,    1'b1, 1'b1},
      '{8'hC1, 1'b1, TYPED,      2'd3, R0,    R1,    R2,    1'b1, 1'b0}
    };
    for (idx = 0; idx < DIR_ROWS; idx++) raw_q.push_back(dir_tbl[idx]);
    gen_random_text(RAND_ITEMS);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (idx = 0; idx < raw_q.size(); idx++) begin
      // Pause once until the output has caught up
      if (idx == DRAIN_AT) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (clean_q.size() != 0);
      end else begin
        gap = sender_gap(idx);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_tvalid <= 1'b1;
      in_tdata  <= raw_q[idx].data;
      in_tlast  <= raw_q[idx].last;
      do @(posedge clk); while (!in_tready);
    end
    in_tvalid <= 1'b0;

    while (clean_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (bad_beats == 0 && clean_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
